[src/integer_square_root_top_assert.svh]
// ---------------------------------------------------------------------------
// Integer square root assertion macros
// Concurrent assertion macros, compiled out with NO_ASSERTIONS.
// ---------------------------------------------------------------------------
`ifndef INTEGER_SQUARE_ROOT_TOP_ASSERT_SVH
`define INTEGER_SQUARE_ROOT_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Checked on every rising clock edge outside of reset.
`define ISQRT_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Checked on every rising clock edge, reset included.
`define ISQRT_ASSERT_ALWAYS(name, prop, msg) \
	name: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define ISQRT_ASSERT(name, prop, msg)
`define ISQRT_ASSERT_ALWAYS(name, prop, msg)

`endif

`endif

[src/isqrt_pkg.sv]
// ---------------------------------------------------------------------------
// Integer square root package
// Widths, step count, data types and the root conversion of the block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package isqrt_pkg;

	localparam int INPUT_WIDTH = 32;
	localparam int ROOT_WIDTH  = 16;

	// Position of the highest even bit below the radicand width.
	localparam int TOP_SHIFT = ((INPUT_WIDTH - 1) / 2) * 2;
	localparam int NUM_STEPS = TOP_SHIFT / 2 + 1;

	typedef logic [INPUT_WIDTH-1:0] word_t;
	typedef logic [ROOT_WIDTH-1:0]  root_t;

	typedef struct packed {
		word_t rem;
		word_t res;
	} step_data_t;

	function automatic root_t to_root(input word_t res);
		logic [ROOT_WIDTH+INPUT_WIDTH-1:0] ext;
		ext = {{ROOT_WIDTH{1'b0}}, res};
		return ext[ROOT_WIDTH-1:0];
	endfunction

endpackage

[src/isqrt_in_if.sv]
// ---------------------------------------------------------------------------
// Integer square root input channel
// Valid/ready channel that carries one radicand per transaction.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface isqrt_in_if;

	logic                 valid;
	logic                 ready;
	isqrt_pkg::word_t     value;

	modport source (output valid, output value, input ready);
	modport sink   (input valid, input value, output ready);

endinterface

[src/isqrt_out_if.sv]
// ---------------------------------------------------------------------------
// Integer square root output channel
// Valid/ready channel that carries one root per transaction.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface isqrt_out_if;

	logic                 valid;
	logic                 ready;
	isqrt_pkg::root_t     root;

	modport source (output valid, output root, input ready);
	modport sink   (input valid, input root, output ready);

endinterface

[src/integer_square_root_top.sv]
// ---------------------------------------------------------------------------
// Integer square root
// Pipelined floor square root of an unsigned radicand.
// ---------------------------------------------------------------------------
// The block takes radicands on the radicand channel and returns the floor
// of their square roots on the result channel, one result per transaction,
// in the order the radicands arrived.
// Each pipeline stage runs one restoring step and decides one root bit, so
// a 32-bit radicand passes through 16 stages.
// The result is registered in every stage in turn and is driven onto the
// result channel from the last stage register.
// Throughput is one transaction per cycle while the receiver keeps ready
// high; up to 16 transactions are in flight at once.
// When the receiver holds ready low, the stalled result stays on the output
// and the stages behind it keep filling until every stage holds an item;
// only then does the radicand channel drop ready. Nothing is lost or
// repeated across a stall.
// Reset clears every stage valid bit, so the pipeline comes out of reset
// empty and ready to accept a radicand.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module integer_square_root_top (
	input  logic         clk,
	input  logic         arst_n,
	isqrt_in_if.sink     radicand,
	isqrt_out_if.source  result
);

	`include "integer_square_root_top_assert.svh"

	logic                  valid [0:isqrt_pkg::NUM_STEPS];
	logic                  ready [0:isqrt_pkg::NUM_STEPS];
	isqrt_pkg::step_data_t data  [0:isqrt_pkg::NUM_STEPS];

	assign valid[0]       = radicand.valid;
	assign radicand.ready = ready[0];
	assign data[0].rem    = radicand.value;
	assign data[0].res    = '0;

	for (genvar i = 0; i < isqrt_pkg::NUM_STEPS; i++) begin : g_stage
		localparam isqrt_pkg::word_t StepBit =
			isqrt_pkg::word_t'(1) << (isqrt_pkg::TOP_SHIFT - 2 * i);

		isqrt_stage u_stage (
			.clk      (clk),
			.arst_n   (arst_n),
			.step_bit (StepBit),
			.up_valid (valid[i]),
			.up_ready (ready[i]),
			.up_data  (data[i]),
			.dn_valid (valid[i+1]),
			.dn_ready (ready[i+1]),
			.dn_data  (data[i+1])
		);
	end

	assign result.valid                 = valid[isqrt_pkg::NUM_STEPS];
	assign ready[isqrt_pkg::NUM_STEPS]  = result.ready;
	assign result.root = isqrt_pkg::to_root(data[isqrt_pkg::NUM_STEPS].res);

	// The remainder left after the last step never exceeds twice the root.
	`ISQRT_ASSERT(a_rem_bound, result.valid |-> ({1'b0, data[isqrt_pkg::NUM_STEPS].rem} <= {data[isqrt_pkg::NUM_STEPS].res, 1'b0}), "final remainder exceeds twice the root")

	// Backpressure only reaches the input when the output is stalled.
	`ISQRT_ASSERT(a_stall_source, !radicand.ready |-> (result.valid && !result.ready), "input stalled while output is free")

	// The pipeline is empty while reset is held.
	`ISQRT_ASSERT_ALWAYS(a_reset_empty, !arst_n |-> !result.valid, "result valid during reset")

endmodule

[src/isqrt_stage.sv]
// ---------------------------------------------------------------------------
// Integer square root pipeline stage
// One restoring step that decides one root bit, followed by a stage register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module isqrt_stage (
	input  logic                    clk,
	input  logic                    arst_n,
	input  isqrt_pkg::word_t        step_bit,
	input  logic                    up_valid,
	output logic                    up_ready,
	input  isqrt_pkg::step_data_t   up_data,
	output logic                    dn_valid,
	input  logic                    dn_ready,
	output isqrt_pkg::step_data_t   dn_data
);

	logic                           valid_s1;
	isqrt_pkg::step_data_t          data_s1;
	isqrt_pkg::step_data_t          nxt;
	logic [isqrt_pkg::INPUT_WIDTH:0] trial;
	logic                           fits;

	always_comb begin
		trial = {1'b0, up_data.res} + {1'b0, step_bit};
		fits  = {1'b0, up_data.rem} >= trial;
		if (fits) begin
			nxt.rem = up_data.rem - trial[isqrt_pkg::INPUT_WIDTH-1:0];
			nxt.res = (up_data.res >> 1) + step_bit;
		end else begin
			nxt.rem = up_data.rem;
			nxt.res = up_data.res >> 1;
		end
	end

	assign up_ready = !valid_s1 || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (up_ready) begin
			valid_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			data_s1 <= nxt;
		end
	end

	assign dn_valid = valid_s1;
	assign dn_data  = data_s1;

endmodule

[sim/isqrt_checker.sv]
// ---------------------------------------------------------------------------
// Integer square root checker
// Watches the radicand and result channels, predicts the floor square root of
// every accepted radicand and compares each result transaction in order.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module isqrt_checker (
	input  logic   clk,
	input  logic   arst_n,
	isqrt_in_if    radicand,
	isqrt_out_if   result,
	output int     errors,
	output int     pending
);

	isqrt_pkg::root_t expected_roots[$];

	function automatic isqrt_pkg::root_t floor_sqrt(input isqrt_pkg::word_t v);
		logic [63:0] rem;
		logic [63:0] acc;
		logic [63:0] probe;
		rem = 64'(v);
		acc = '0;
		for (probe = 64'd1 << (((isqrt_pkg::INPUT_WIDTH - 1) / 2) * 2); probe != 0;
				probe = probe >> 2) begin
			if (rem >= acc + probe) begin
				rem = rem - (acc + probe);
				acc = (acc >> 1) + probe;
			end else begin
				acc = acc >> 1;
			end
		end
		return acc[isqrt_pkg::ROOT_WIDTH-1:0];
	endfunction

	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		errors++;
	endtask

	initial begin
		errors = 0;
	end

	assign pending = expected_roots.size();

	always @(posedge clk) begin
		isqrt_pkg::root_t want;
		if (arst_n) begin
			if (radicand.valid && radicand.ready)
				expected_roots.push_back(floor_sqrt(radicand.value));
			if (result.valid && result.ready) begin
				if (expected_roots.size() == 0) begin
					report_mismatch($sformatf("unexpected root %0d", result.root));
				end else begin
					want = expected_roots.pop_front();
					if (result.root !== want)
						report_mismatch($sformatf("root %0d, expected %0d", result.root, want));
				end
			end
		end
	end

endmodule

[sim/tb_integer_square_root_top.sv]
// ---------------------------------------------------------------------------
// Integer square root testbench
// Drives directed and random radicands with random idle cycles on both
// channels and a long receiver hold-off; the checker predicts each root.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_integer_square_root_top;

	localparam int RANDOM_ITEMS = 1600;
	localparam int HOLD_CYCLES  = 120;
	localparam int STALL_LIMIT  = 1000;

	logic clk;
	logic arst_n;
	int   errors;
	int   pending;
	int   sent;
	int   stall_cycles;
	bit   hold_off;
	bit   steady;

	isqrt_in_if  radicand_ch();
	isqrt_out_if result_ch();

	integer_square_root_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.radicand (radicand_ch),
		.result   (result_ch)
	);

	isqrt_checker checker_i (
		.clk      (clk),
		.arst_n   (arst_n),
		.radicand (radicand_ch),
		.result   (result_ch),
		.errors   (errors),
		.pending  (pending)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	task automatic send_radicand(input isqrt_pkg::word_t v);
		while (!hold_off && !steady && $urandom_range(99) < 27) begin
			radicand_ch.valid <= 1'b0;
			@(posedge clk);
		end
		radicand_ch.valid <= 1'b1;
		radicand_ch.value <= v;
		@(posedge clk);
		while (!radicand_ch.ready)
			@(posedge clk);
		sent++;
	endtask

	function automatic isqrt_pkg::word_t random_radicand();
		int unsigned kind;
		int unsigned r;
		kind = $urandom_range(99);
		r = $urandom_range(65535);
		if (kind < 40)
			return isqrt_pkg::word_t'($urandom);
		else if (kind < 60)
			return isqrt_pkg::word_t'(r * r);
		else if (kind < 75)
			return isqrt_pkg::word_t'(r * r + 2 * r);
		else if (kind < 90)
			return isqrt_pkg::word_t'($urandom_range(1000));
		else
			return {16'hFFFF, 16'($urandom)};
	endfunction

	// Receiver: random idling, one long hold-off after 400 radicands are sent,
	// and a stretch of steady acceptance while the sender is steady too.
	initial begin
		int cyc;
		bit held;
		cyc = 0;
		held = 0;
		hold_off = 0;
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			cyc++;
			if (!held && sent >= 400) begin
				held = 1;
				hold_off = 1;
				result_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_off = 0;
				result_ch.ready <= 1'b1;
			end else if (steady) begin
				result_ch.ready <= 1'b1;
			end else begin
				result_ch.ready <= ($urandom_range(99) >= 27);
			end
		end
	end

	always @(posedge clk) begin
		if ((radicand_ch.valid && radicand_ch.ready) || (result_ch.valid && result_ch.ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		isqrt_pkg::word_t directed[] = '{
			32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd8, 32'd15, 32'd16,
			32'd24, 32'd25, 32'd99, 32'd100,
			32'h0000_FFFF, 32'h0001_0000,
			32'h3FFF_FFFF, 32'h4000_0000,
			32'h7FFF_FFFF, 32'h8000_0000,
			32'hAAAA_AAAA, 32'h5555_5555,
			32'hFFFE_0000, 32'hFFFE_0001, 32'hFFFF_FFFE, 32'hFFFF_FFFF
		};
		arst_n = 1'b0;
		sent = 0;
		steady = 0;
		stall_cycles = 0;
		radicand_ch.valid <= 1'b0;
		radicand_ch.value <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i])
			send_radicand(directed[i]);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			steady = (n >= 1000 && n < 1200);
			send_radicand(random_radicand());
		end
		steady = 0;
		radicand_ch.valid <= 1'b0;

		while (pending != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);

		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
